>>> rtl/fdss_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdss_pkg
// shared types, constants and the glyph table of the display scanner
// ----------------------------------------------------------------------------
package fdss_pkg;

	localparam int unsigned VALUE_W  = 14;
	localparam int unsigned IN_W     = 16;
	localparam int unsigned DIGIT_W  = 4;
	localparam int unsigned SEG_W    = 8;
	localparam int unsigned EN_W     = 4;
	localparam int unsigned INDEX_W  = 2;

	localparam logic [VALUE_W-1:0] VALUE_MAX = VALUE_W'(9999);

	// item kinds
	localparam logic REQ_SET  = 1'b0;
	localparam logic REQ_TICK = 1'b1;

	// digit positions, thousands first
	localparam logic [INDEX_W-1:0] POS_THOU  = 2'd0;
	localparam logic [INDEX_W-1:0] POS_HUND  = 2'd1;
	localparam logic [INDEX_W-1:0] POS_TENS  = 2'd2;
	localparam logic [INDEX_W-1:0] POS_UNITS = 2'd3;

	localparam logic [SEG_W-1:0] LIT_BLANK = 8'h00;
	localparam logic [SEG_W-1:0] LIT_DP    = 8'h80;

	typedef struct packed {
		logic [DIGIT_W-1:0] thou;
		logic [DIGIT_W-1:0] hund;
		logic [DIGIT_W-1:0] tens;
		logic [DIGIT_W-1:0] units;
	} digits_t;

	// segments a..g lit pattern, active high
	function automatic logic [SEG_W-1:0] glyph(input logic [DIGIT_W-1:0] d);
		logic [SEG_W-1:0] g;
		case (d)
			4'd0: g = 8'h3F;
			4'd1: g = 8'h06;
			4'd2: g = 8'h5B;
			4'd3: g = 8'h4F;
			4'd4: g = 8'h66;
			4'd5: g = 8'h6D;
			4'd6: g = 8'h7D;
			4'd7: g = 8'h07;
			4'd8: g = 8'h7F;
			4'd9: g = 8'h6F;
			default: g = LIT_BLANK;
		endcase
		return g;
	endfunction

endpackage

>>> rtl/fdss_digit_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdss_digit_stage
// peels one decimal digit off a value by compare against the nine multiples
// ----------------------------------------------------------------------------
module fdss_digit_stage #(
	parameter int unsigned WEIGHT = 1000
) (
	input  logic [fdss_pkg::VALUE_W-1:0] rem_in,
	output logic [fdss_pkg::DIGIT_W-1:0] digit,
	output logic [fdss_pkg::VALUE_W-1:0] rem_out
);

	logic [fdss_pkg::VALUE_W-1:0] sub;

	always_comb begin
		digit = '0;
		sub   = '0;
		for (int k = 1; k < 10; k++) begin
			if (rem_in >= fdss_pkg::VALUE_W'(k * WEIGHT)) begin
				digit = fdss_pkg::DIGIT_W'(k);
				sub   = fdss_pkg::VALUE_W'(k * WEIGHT);
			end
		end
		rem_out = rem_in - sub;
	end

endmodule

>>> rtl/fdss_glyph.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdss_glyph
// picks the digit under scan, applies blanking and the decimal point
// ----------------------------------------------------------------------------
module fdss_glyph (
	input  fdss_pkg::digits_t             digits,
	input  logic [fdss_pkg::INDEX_W-1:0]  pos,
	output logic [fdss_pkg::SEG_W-1:0]    segments,
	output logic [fdss_pkg::EN_W-1:0]     enable
);

	logic [fdss_pkg::SEG_W-1:0] lit;
	logic                       thou_blank;
	logic                       hund_blank;

	// leading zeros mean the value is below 1000 or 100
	assign thou_blank = (digits.thou == '0);
	assign hund_blank = thou_blank && (digits.hund == '0);

	always_comb begin
		case (pos)
			fdss_pkg::POS_THOU:
				lit = thou_blank ? fdss_pkg::LIT_BLANK : fdss_pkg::glyph(digits.thou);
			fdss_pkg::POS_HUND:
				lit = hund_blank ? fdss_pkg::LIT_BLANK : fdss_pkg::glyph(digits.hund);
			fdss_pkg::POS_TENS:
				lit = fdss_pkg::glyph(digits.tens) | fdss_pkg::LIT_DP;
			default:
				lit = fdss_pkg::glyph(digits.units);
		endcase
	end

	assign segments = ~lit;
	assign enable   = fdss_pkg::EN_W'(1) << pos;

endmodule

>>> rtl/four_digit_seven_segment_scanner.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// four_digit_seven_segment_scanner
// scan driver for a four digit multiplexed seven segment display
// ----------------------------------------------------------------------------
// input channel (req_valid / req_ready): one item carries req_type and value.
//   a set item stores value, saturated to 9999, and gives no result
//   a tick item gives one result for the digit under scan, then the scan
//   position moves on, thousands to units and round again
// result channel (res_valid / res_ready): segment_levels (active low, bit7 is
//   the decimal point, lit on the tens digit) and a one-hot digit_enable
// the value is split into decimal digits on its way in: thousands, hundreds
//   and tens each take one compare stage, so a set runs through the pipe
//   registers before it lands in the digit store; a tick reads the store at the
//   same point, so items always see every set accepted before them
// throughput: one item per cycle while the receiver takes results
// stall: the whole pipe holds while a result waits and res_ready is low;
//   req_ready is high whenever the result register is empty or being taken
// reset: value 0 and scan position at the thousands digit, pipe empty
// ----------------------------------------------------------------------------
module four_digit_seven_segment_scanner (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           req_valid,
	output logic                           req_ready,
	input  logic                           req_type,
	input  logic [fdss_pkg::IN_W-1:0]      value,
	output logic                           res_valid,
	input  logic                           res_ready,
	output logic [fdss_pkg::SEG_W-1:0]     segment_levels,
	output logic [fdss_pkg::EN_W-1:0]      digit_enable
);

	// pipe advance: result register empty or drained this cycle
	logic advance;

	// stage 1: saturated value
	logic                          valid_s1;
	logic                          tick_s1;
	logic [fdss_pkg::VALUE_W-1:0]  val_s1;

	// stage 2: thousands split off
	logic                          valid_s2;
	logic                          tick_s2;
	logic [fdss_pkg::VALUE_W-1:0]  rem_s2;
	logic [fdss_pkg::DIGIT_W-1:0]  thou_s2;

	// stage 3: hundreds split off
	logic                          valid_s3;
	logic                          tick_s3;
	logic [fdss_pkg::VALUE_W-1:0]  rem_s3;
	logic [fdss_pkg::DIGIT_W-1:0]  thou_s3;
	logic [fdss_pkg::DIGIT_W-1:0]  hund_s3;

	// stage combinational outputs
	logic [fdss_pkg::DIGIT_W-1:0]  thou_d;
	logic [fdss_pkg::VALUE_W-1:0]  rem_thou;
	logic [fdss_pkg::DIGIT_W-1:0]  hund_d;
	logic [fdss_pkg::VALUE_W-1:0]  rem_hund;
	logic [fdss_pkg::DIGIT_W-1:0]  tens_d;
	logic [fdss_pkg::VALUE_W-1:0]  rem_tens;

	// display state
	fdss_pkg::digits_t             digits_q;
	logic [fdss_pkg::INDEX_W-1:0]  pos_q;

	// decoded result for the digit under scan
	logic [fdss_pkg::SEG_W-1:0]    seg_d;
	logic [fdss_pkg::EN_W-1:0]     en_d;

	logic                          commit_set;
	logic                          commit_tick;

	assign advance   = !res_valid || res_ready;
	assign req_ready = advance;

	assign commit_set  = advance && valid_s3 && (tick_s3 == fdss_pkg::REQ_SET);
	assign commit_tick = advance && valid_s3 && (tick_s3 == fdss_pkg::REQ_TICK);

	// pipe valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= req_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	// pipe payload, no reset needed
	always_ff @(posedge clk) begin
		if (advance) begin
			tick_s1 <= req_type;
			// saturate anything above 9999
			val_s1  <= (value > fdss_pkg::IN_W'(fdss_pkg::VALUE_MAX)) ?
				fdss_pkg::VALUE_MAX : value[fdss_pkg::VALUE_W-1:0];
			tick_s2 <= tick_s1;
			rem_s2  <= rem_thou;
			thou_s2 <= thou_d;
			tick_s3 <= tick_s2;
			rem_s3  <= rem_hund;
			thou_s3 <= thou_s2;
			hund_s3 <= hund_d;
		end
	end

	fdss_digit_stage #(.WEIGHT(1000)) u_thou (
		.rem_in  (val_s1),
		.digit   (thou_d),
		.rem_out (rem_thou)
	);

	fdss_digit_stage #(.WEIGHT(100)) u_hund (
		.rem_in  (rem_s2),
		.digit   (hund_d),
		.rem_out (rem_hund)
	);

	fdss_digit_stage #(.WEIGHT(10)) u_tens (
		.rem_in  (rem_s3),
		.digit   (tens_d),
		.rem_out (rem_tens)
	);

	// digit store and scan position move only as items leave the pipe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			digits_q <= '0;
			pos_q    <= fdss_pkg::POS_THOU;
		end else begin
			if (commit_set) begin
				digits_q.thou  <= thou_s3;
				digits_q.hund  <= hund_s3;
				digits_q.tens  <= tens_d;
				digits_q.units <= rem_tens[fdss_pkg::DIGIT_W-1:0];
			end
			if (commit_tick) begin
				pos_q <= pos_q + fdss_pkg::INDEX_W'(1);
			end
		end
	end

	fdss_glyph u_glyph (
		.digits   (digits_q),
		.pos      (pos_q),
		.segments (seg_d),
		.enable   (en_d)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid <= 1'b0;
		end else if (advance) begin
			res_valid <= commit_tick;
		end
	end

	always_ff @(posedge clk) begin
		if (commit_tick) begin
			segment_levels <= seg_d;
			digit_enable   <= en_d;
		end
	end

	// a shown result drives exactly one digit
	a_one_digit: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> $onehot(digit_enable))
		else $error("digit enable not one-hot");

	// every tick leaving the pipe turns into a result
	a_tick_result: assert property (@(posedge clk) disable iff (!arst_n)
		commit_tick |=> res_valid)
		else $error("tick lost at result register");

	// scan position moves only with a tick
	a_pos_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!commit_tick |=> $stable(pos_q))
		else $error("scan position moved without a tick");

	// stored digits are always decimal
	a_digits_bcd: assert property (@(posedge clk) disable iff (!arst_n)
		(digits_q.thou <= 4'd9) && (digits_q.hund <= 4'd9) &&
		(digits_q.tens <= 4'd9) && (digits_q.units <= 4'd9))
		else $error("digit store holds a non-decimal digit");

	// a stalled pipe keeps its scan position and digits
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(digits_q) && $stable(pos_q))
		else $error("display state changed during a stall");

endmodule
